>>> hdl/wts_pkg.sv
// types and constants shared by the weighted table sampler
// no dependencies; compile first
package wts_pkg;

    localparam int TYPE_W   = 2;
    localparam int MASK_W   = 52;
    localparam int WEIGHT_W = 16;
    localparam int VALUE_W  = 26;
    localparam int TRIALS_W = 4;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = MASK_W + 2 * VALUE_W;

    localparam logic [TRIALS_W-1:0] TRIALS_RESET = 4'd10;

    // request kinds
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_DRAW  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_GAVE_UP = 3'd6;

    typedef struct packed {
        logic [TYPE_W-1:0]          req_type;
        logic [MASK_W-1:0]          item_mask;
        logic signed [WEIGHT_W-1:0] weight;
        logic [MASK_W-1:0]          dead_mask;
        logic [VALUE_W-1:0]         random_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MASK_W-1:0]   drawn_mask;
        logic [VALUE_W-1:0]  total_out;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_RESP
    } state_t;

endpackage

>>> hdl/wts_if.sv
// valid/ready channel interfaces: request, response and configuration write
// depends on wts_pkg
interface wts_req_if;
    logic          valid;
    logic          ready;
    wts_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wts_rsp_if;
    logic          valid;
    logic          ready;
    wts_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wts_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wts_pkg::TRIALS_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/weighted_table_sampler.sv
// weighted table sampler: one request in flight, result in an output register
// clear, load and unknown kinds pass from acceptance through the execute and response states;
// a draw reads the midpoint entry in the execute state and compares it in the wait state, per probe,
// until the value is found or the window runs empty, with probes <= clog2(entries + 1)
// the next request is taken in the cycle after the result leaves the working stage
// reset (rst_n, async, active low) empties the table at once; no clearing pass
module weighted_table_sampler #(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    wts_cfg_if.sink    cfg,
    wts_req_if.sink    req,
    wts_rsp_if.source  rsp
);
    import wts_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // table memory: each entry holds {mask, start, end}
    logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    // control state
    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [VALUE_W-1:0]  total_reg,  total_next;
    logic [TRIALS_W-1:0] fail_reg,   fail_next;
    logic [TRIALS_W-1:0] trials_reg;
    // search window [lo, hi)
    logic [CNT_W-1:0]    lo_reg,     lo_next;
    logic [CNT_W-1:0]    hi_reg,     hi_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    req_t                req_reg,    req_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [MASK_W-1:0]   res_mask_reg,   res_mask_next;
    rsp_t                out_data_reg,   out_data_next;

    // datapath helpers
    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid;
    logic [MASK_W-1:0]   rd_mask;
    logic [VALUE_W-1:0]  rd_start;
    logic [VALUE_W-1:0]  rd_end;
    logic                load_bad;
    logic [VALUE_W:0]    load_sum;
    logic                load_full;
    logic [TRIALS_W-1:0] trial_limit;
    logic [TRIALS_W:0]   fail_inc;
    logic                give_up;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // midpoint of the window; lo < hi <= depth keeps it inside the table
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid     = mid_sum[IDX_W:1];

    assign rd_mask  = rd_data_reg[ENTRY_W-1 -: MASK_W];
    assign rd_start = rd_data_reg[2*VALUE_W-1 -: VALUE_W];
    assign rd_end   = rd_data_reg[VALUE_W-1:0];

    // a load is skipped for weight below one or overlap with the dead set
    assign load_bad  = req_reg.weight[WEIGHT_W-1] || (req_reg.weight == '0)
                       || ((req_reg.item_mask & req_reg.dead_mask) != '0);
    assign load_sum  = {1'b0, total_reg}
                       + {{(VALUE_W + 1 - WEIGHT_W){1'b0}}, req_reg.weight};
    // full when every slot is taken or the total would overflow
    assign load_full = (count_reg >= CNT_W'(TABLE_DEPTH)) || load_sum[VALUE_W];

    // a limit of zero behaves as one
    assign trial_limit = (trials_reg == '0) ? TRIALS_W'(1) : trials_reg;
    assign fail_inc    = {1'b0, fail_reg} + (TRIALS_W + 1)'(1);
    assign give_up     = (fail_inc >= {1'b0, trial_limit});

    assign mem_waddr = count_reg[IDX_W-1:0];
    assign mem_wdata = {req_reg.item_mask, total_reg, load_sum[VALUE_W-1:0]};
    assign mem_raddr = mid;

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            fail_reg      <= '0;
            trials_reg    <= TRIALS_RESET;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            fail_reg      <= fail_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                trials_reg <= cfg.data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_mask_reg   <= res_mask_next;
        out_data_reg   <= out_data_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        fail_next       = fail_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_mask_next   = res_mask_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next   = req.data;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_mask_next = '0;
                state_next    = S_RESP;
                unique case (req_reg.req_type)
                    REQ_CLEAR:
                    begin
                        count_next      = '0;
                        total_next      = '0;
                        fail_next       = '0;
                        res_status_next = ST_CLEARED;
                    end
                    REQ_LOAD:
                    begin
                        if (load_bad)
                        begin
                            res_status_next = ST_SKIPPED;
                        end
                        else if (load_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            total_next      = load_sum[VALUE_W-1:0];
                            res_status_next = ST_LOADED;
                        end
                    end
                    REQ_DRAW:
                    begin
                        if (lo_reg < hi_reg)
                        begin
                            // probe the midpoint, compare next cycle
                            mem_re     = 1'b1;
                            state_next = S_WAIT;
                        end
                        else
                        begin
                            // window empty: failed attempt
                            fail_next       = give_up ? '0 : fail_inc[TRIALS_W-1:0];
                            res_status_next = give_up ? ST_GAVE_UP : ST_MISS;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_SKIPPED;
                    end
                endcase
            end

            S_WAIT:
            begin
                priority if ((rd_start < req_reg.random_value)
                             && (rd_end >= req_reg.random_value))
                begin
                    state_next = S_RESP;
                    if ((rd_mask & req_reg.dead_mask) == '0)
                    begin
                        fail_next       = '0;
                        res_mask_next   = rd_mask;
                        res_status_next = ST_HIT;
                    end
                    else
                    begin
                        // found entry is dead: failed attempt
                        res_mask_next   = '0;
                        fail_next       = give_up ? '0 : fail_inc[TRIALS_W-1:0];
                        res_status_next = give_up ? ST_GAVE_UP : ST_MISS;
                    end
                end
                else if (rd_start > req_reg.random_value)
                begin
                    hi_next    = CNT_W'(mid);
                    state_next = S_EXEC;
                end
                else
                begin
                    lo_next    = CNT_W'(mid) + CNT_W'(1);
                    state_next = S_EXEC;
                end
            end

            S_RESP:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = res_status_reg;
                    out_data_next.drawn_mask = res_mask_reg;
                    out_data_next.total_out  = total_reg;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/wts_checker.sv
// port-level checks for the weighted table sampler, bound to the top level
// depends on wts_pkg and weighted_table_sampler
module wts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [wts_pkg::STATUS_W-1:0] rsp_status,
    input logic [wts_pkg::MASK_W-1:0]   rsp_drawn_mask,
    input logic [wts_pkg::VALUE_W-1:0]  rsp_total_out
);
    import wts_pkg::*;

    // a result beat is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped before it was taken");

    // only a hit carries a mask
    a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_HIT) |-> (rsp_drawn_mask == '0))
        else $error("non-hit result carries a mask");

    // a clear leaves no weight behind
    a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_CLEARED) |-> (rsp_total_out == '0))
        else $error("cleared result with nonzero total");

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

endmodule

bind weighted_table_sampler wts_checker u_wts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.data.status),
    .rsp_drawn_mask (rsp.data.drawn_mask),
    .rsp_total_out  (rsp.data.total_out)
);

>>> dv/testbench.sv
// self-checking testbench for the weighted table sampler: directed table, a long table
// fill and random phases under several give-up limits, checked against typed results or a predictor
// depends on wts_pkg, the channel interfaces in hdl/wts_if.sv and the sampler RTL
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wts_pkg::*;

    localparam int DEPTH         = 2048;
    localparam int PLAN_LEN      = 25;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 180;
    localparam int FILL_LOADS    = 400;
    localparam int FULL_DRAWS    = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    // the one request kind the package does not name
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [MASK_W-1:0]          ALL_CARDS = '1;
    localparam logic [VALUE_W-1:0]         VALUE_TOP = '1;
    localparam logic signed [WEIGHT_W-1:0] W_MAX     = 16'sh7FFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN     = 16'sh8000;
    localparam logic signed [WEIGHT_W-1:0] W_NEG_ONE = 16'shFFFF;

    // one directed step: the request and, where it is obvious, the result typed in
    typedef struct {
        req_t stim;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    // idle and stall rates in percent, both sides
    int gap_pct;
    int stall_pct;
    int mismatches;
    int items_sent;

    wts_req_if req_ch ();
    wts_rsp_if rsp_ch ();
    wts_cfg_if cfg_ch ();

    weighted_table_sampler #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor copy of the table and the counters
    logic [MASK_W-1:0]   card_sets [DEPTH];
    logic [VALUE_W-1:0]  span_lo   [DEPTH];
    logic [VALUE_W-1:0]  span_hi   [DEPTH];
    int unsigned         loaded;
    int unsigned         weight_sum;
    int unsigned         miss_streak;
    logic [TRIALS_W-1:0] trials_cfg;

    // results still owed by the block, oldest first
    rsp_t      outcomes_due [$];
    plan_row_t plan [PLAN_LEN];

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // what the sampler answers to one request; updates the predictor state
    function automatic rsp_t sampler_outcome(input req_t stim);
        rsp_t        res;
        int          lo_i;
        int          hi_i;
        int          mid;
        int          hit_at;
        int unsigned limit;
        int unsigned w;

        res        = '0;
        res.status = ST_SKIPPED;
        hit_at     = -1;
        w          = int'(stim.weight);
        case (stim.req_type)
            REQ_CLEAR:
            begin
                loaded      = 0;
                weight_sum  = 0;
                miss_streak = 0;
                res.status  = ST_CLEARED;
            end
            REQ_LOAD:
            begin
                // the skip test wins over the full test
                if ($signed(stim.weight) < 1 || (stim.item_mask & stim.dead_mask) != '0)
                    res.status = ST_SKIPPED;
                else if (loaded >= DEPTH || weight_sum + w > VALUE_TOP)
                    res.status = ST_FULL;
                else
                begin
                    card_sets[loaded] = stim.item_mask;
                    span_lo[loaded]   = VALUE_W'(weight_sum);
                    weight_sum        = weight_sum + w;
                    span_hi[loaded]   = VALUE_W'(weight_sum);
                    loaded            = loaded + 1;
                    res.status        = ST_LOADED;
                end
            end
            REQ_DRAW:
            begin
                // search for the interval (lo, hi] holding the value
                lo_i = 0;
                hi_i = int'(loaded) - 1;
                while (hit_at < 0 && lo_i <= hi_i)
                begin
                    mid = (lo_i + hi_i) / 2;
                    if (span_lo[mid] < stim.random_value && span_hi[mid] >= stim.random_value)
                        hit_at = mid;
                    else if (span_lo[mid] > stim.random_value)
                        hi_i = mid - 1;
                    else
                        lo_i = mid + 1;
                end
                if (hit_at >= 0 && (card_sets[hit_at] & stim.dead_mask) == '0)
                begin
                    res.drawn_mask = card_sets[hit_at];
                    miss_streak    = 0;
                    res.status     = ST_HIT;
                end
                else
                begin
                    // a limit of zero behaves as one
                    limit       = (trials_cfg == '0) ? 1 : trials_cfg;
                    miss_streak = miss_streak + 1;
                    if (miss_streak >= limit)
                    begin
                        miss_streak = 0;
                        res.status  = ST_GAVE_UP;
                    end
                    else
                        res.status = ST_MISS;
                end
            end
            default:
            begin
                // unknown kind: nothing changes, reported as skipped
            end
        endcase
        res.total_out = VALUE_W'(weight_sum);
        return res;
    endfunction

    function automatic plan_row_t plan_row(input logic [TYPE_W-1:0] kind,
                                           input logic [MASK_W-1:0] cards,
                                           input logic signed [WEIGHT_W-1:0] wt,
                                           input logic [MASK_W-1:0] dead,
                                           input logic [VALUE_W-1:0] val,
                                           input bit typed,
                                           input logic [STATUS_W-1:0] st,
                                           input logic [MASK_W-1:0] drawn,
                                           input logic [VALUE_W-1:0] tot);
        plan_row_t row;

        row.stim  = '{kind, cards, wt, dead, val};
        row.typed = typed;
        row.want  = '{st, drawn, tot};
        return row;
    endfunction

    function automatic logic [MASK_W-1:0] random_cards();
        return MASK_W'({$urandom(), $urandom()});
    endfunction

    // a hand of one to three cards, so that overlaps stay the exception
    function automatic logic [MASK_W-1:0] sparse_cards();
        logic [MASK_W-1:0] m;

        m = '0;
        repeat ($urandom_range(3, 1))
            m[$urandom_range(MASK_W - 1, 0)] = 1'b1;
        return m;
    endfunction

    function automatic logic [MASK_W-1:0] pick_cards();
        return ($urandom_range(99) < 60) ? sparse_cards() : random_cards();
    endfunction

    function automatic logic [MASK_W-1:0] pick_dead();
        int r;

        r = $urandom_range(99);
        if (r < 45)
            return '0;
        if (r < 85)
            return sparse_cards();
        return random_cards();
    endfunction

    // a draw, mostly inside the current total so that hits are common
    function automatic req_t next_draw();
        req_t d;

        d.req_type  = REQ_DRAW;
        d.item_mask = random_cards();
        d.weight    = WEIGHT_W'($urandom());
        d.dead_mask = pick_dead();
        if ($urandom_range(99) < 85)
            d.random_value = VALUE_W'($urandom_range(weight_sum + 3, 0));
        else
            d.random_value = VALUE_W'($urandom());
        return d;
    endfunction

    // one request beat; valid stays up into the next call unless that call idles first
    task automatic offer_request(input req_t stim, input bit typed, input rsp_t want);
        rsp_t predicted;

        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= stim;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = sampler_outcome(stim);
        outcomes_due.insert(outcomes_due.size(), typed ? want : predicted);
        if (stim.req_type != REQ_UNKNOWN)
            items_sent++;
    endtask

    // hold the request side until every owed result has come back
    task automatic await_outcomes();
        req_ch.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_trials(input logic [TRIALS_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        trials_cfg = val;
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // every result beat is matched against the oldest owed result
    always @(posedge clk)
    begin : check_results
        rsp_t due;
        rsp_t got;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (outcomes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t: result beat with nothing owed: status %0d mask %h total %0d",
                             $realtime, got.status, got.drawn_mask, got.total_out);
            end
            else
            begin
                due = outcomes_due.pop_front();
                if (got.status !== due.status || got.drawn_mask !== due.drawn_mask ||
                    got.total_out !== due.total_out)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%t: mismatch: status %0d/%0d mask %h/%h total %0d/%0d %s",
                                 $realtime, due.status, got.status, due.drawn_mask,
                                 got.drawn_mask, due.total_out, got.total_out,
                                 "(expected/actual)");
                end
            end
        end
    end

    initial
    begin : stimulus
        req_t                stim;
        int                  r;
        int                  w;
        logic [TRIALS_W-1:0] setting;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        gap_pct      = 30;
        stall_pct    = 30;
        mismatches   = 0;
        items_sent   = 0;
        loaded       = 0;
        weight_sum   = 0;
        miss_streak  = 0;
        trials_cfg   = TRIALS_RESET;

        // directed steps at the reset give-up limit of ten; misses pile up to a give-up
        plan = '{
            // empty table: zero value, top value, everything dead
            plan_row(REQ_DRAW, '0, '0, '0, '0, 1, ST_MISS, '0, '0),
            plan_row(REQ_DRAW, '0, '0, '0, VALUE_TOP, 1, ST_MISS, '0, '0),
            plan_row(REQ_DRAW, '0, '0, ALL_CARDS, 26'd1, 1, ST_MISS, '0, '0),
            plan_row(REQ_DRAW, ALL_CARDS, W_MAX, '0, 26'd1, 0, ST_MISS, '0, '0),
            // weights below one are skipped
            plan_row(REQ_LOAD, ALL_CARDS, '0, '0, '0, 1, ST_SKIPPED, '0, '0),
            plan_row(REQ_LOAD, ALL_CARDS, W_MIN, '0, '0, 1, ST_SKIPPED, '0, '0),
            plan_row(REQ_LOAD, ALL_CARDS, W_NEG_ONE, '0, '0, 1, ST_SKIPPED, '0, '0),
            // three entries: (0,1], (1,32768], (32768,32773]
            plan_row(REQ_LOAD, 52'h1, 16'sd1, '0, '0, 1, ST_LOADED, '0, 26'd1),
            plan_row(REQ_LOAD, ALL_CARDS, W_MAX, '0, '0, 1, ST_LOADED, '0, 26'd32768),
            plan_row(REQ_LOAD, 52'hF0, 16'sd5, ALL_CARDS ^ 52'hF0, VALUE_TOP,
                     1, ST_LOADED, '0, 26'd32773),
            // overlap with the dead cards
            plan_row(REQ_LOAD, 52'h3, 16'sd100, 52'h2, '0, 1, ST_SKIPPED, '0, 26'd32773),
            // misses: zero, just past the total, top value, dead hit
            plan_row(REQ_DRAW, '0, '0, '0, '0, 1, ST_MISS, '0, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, '0, 26'd32774, 1, ST_MISS, '0, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, '0, VALUE_TOP, 1, ST_MISS, '0, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, ALL_CARDS, 26'd5, 1, ST_MISS, '0, 26'd32773),
            // unknown kind leaves the streak alone
            plan_row(REQ_UNKNOWN, ALL_CARDS, W_NEG_ONE, ALL_CARDS, VALUE_TOP,
                     1, ST_SKIPPED, '0, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, '0, 26'd32800, 0, ST_MISS, '0, '0),
            // tenth failure in a row
            plan_row(REQ_DRAW, '0, '0, 52'h10, 26'd32770, 1, ST_GAVE_UP, '0, 26'd32773),
            // value on the edge shared by the first two intervals, left to the predictor
            plan_row(REQ_DRAW, '0, '0, ALL_CARDS ^ 52'h1, 26'd1, 0, ST_HIT, 52'h1, 26'd32773),
            // hits on the edges of the other intervals
            plan_row(REQ_DRAW, '0, '0, '0, 26'd2, 1, ST_HIT, ALL_CARDS, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, '0, 26'd32768, 1, ST_HIT, ALL_CARDS, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, '0, 26'd32769, 1, ST_HIT, 52'hF0, 26'd32773),
            plan_row(REQ_DRAW, '0, '0, '0, 26'd32773, 1, ST_HIT, 52'hF0, 26'd32773),
            plan_row(REQ_CLEAR, ALL_CARDS, W_NEG_ONE, ALL_CARDS, VALUE_TOP,
                     1, ST_CLEARED, '0, '0),
            plan_row(REQ_DRAW, '0, '0, '0, 26'd1, 1, ST_MISS, '0, '0)
        };

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer_request(plan[i].stim, plan[i].typed, plan[i].want);

        // a long fill with no idling on either side
        await_outcomes();
        gap_pct   = 0;
        stall_pct = 0;
        offer_request('{REQ_CLEAR, random_cards(), W_MAX, random_cards(), VALUE_TOP}, 0, '0);
        repeat (FILL_LOADS)
            offer_request('{REQ_LOAD, pick_cards(), W_MAX, '0, VALUE_W'($urandom())}, 0, '0);
        // a zero weight is a skip
        offer_request('{REQ_LOAD, sparse_cards(), '0, '0, '0}, 0, '0);
        gap_pct   = 30;
        stall_pct = 30;
        // deep searches over the filled table
        repeat (FULL_DRAWS)
            offer_request(next_draw(), 0, '0);

        // random phases: reset limit first, then one, fifteen, zero and a random one
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                await_outcomes();
                case (phase)
                    1:       setting = 4'd1;
                    2:       setting = 4'd15;
                    3:       setting = 4'd0;
                    default: setting = TRIALS_W'($urandom_range(14, 2));
                endcase
                write_trials(setting);
            end
            r = items_sent + PHASE_ITEMS;
            while (items_sent < r)
            begin
                if ($urandom_range(99) < 85)
                begin
                    // well-formed: optional clear, a batch of loads, a batch of draws
                    if ($urandom_range(99) < 70)
                        offer_request('{REQ_CLEAR, random_cards(), WEIGHT_W'($urandom()),
                                        random_cards(), VALUE_W'($urandom())}, 0, '0);
                    repeat (($urandom_range(9) == 0) ? $urandom_range(150, 25)
                                                     : $urandom_range(20, 1))
                    begin
                        w = $urandom_range(99);
                        if (w < 75)
                            w = $urandom_range(200, 1);
                        else if (w < 85)
                            w = $urandom_range(32767, 1);
                        else
                            w = $urandom();
                        offer_request('{REQ_LOAD, pick_cards(), WEIGHT_W'(w), pick_dead(),
                                        VALUE_W'($urandom())}, 0, '0);
                    end
                    repeat ($urandom_range(30, 1))
                        offer_request(next_draw(), 0, '0);
                    // now and then let the block run dry before going on
                    if ($urandom_range(19) == 0)
                        await_outcomes();
                end
                else
                begin
                    // noise: any kind, any fields
                    stim = '{TYPE_W'($urandom()), random_cards(), WEIGHT_W'($urandom()),
                             random_cards(), VALUE_W'($urandom())};
                    offer_request(stim, 0, '0);
                end
            end
        end

        await_outcomes();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
